FILE: rtl/tga_pkg.sv
// Package for the TGA stream parser: field widths, result kinds, error codes.
// No dependencies.
`timescale 1ns / 1ps
package tga_pkg;

  localparam int HeaderLength  = 18;
  localparam int InDataW       = 8;
  localparam int OutDataW      = 64; // 8+8+8+16+16+3+1 = 60, padded to bytes
  localparam int OutUserW      = 2;
  localparam int QueueDepthDef = 2;
  localparam logic [7:0] Depth24 = 8'd24;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_MAP    = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_EARLY  = 3'd1,
    ERR_DEPTH  = 3'd2,
    ERR_ALPHA  = 3'd3,
    ERR_MAPSZ  = 3'd4
  } err_t;

  // One classified input beat passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } beat_t;

  // One result item
  typedef struct packed {
    logic        image_done;
    logic [2:0]  error_code;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } res_t;

endpackage

FILE: rtl/tga_front.sv
// Front: accepts input beats into a short queue.
// Depends on tga_pkg.
`timescale 1ns / 1ps
module tga_front #(
  parameter int Depth = tga_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tga_pkg::beat_t     in_beat,
  output logic               q_valid,
  input  logic               q_ready,
  output tga_pkg::beat_t     q_beat
);
  import tga_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  beat_t          mem_r [Depth];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_tready = (cnt_r != (AW+1)'(Depth));
  assign q_valid   = (cnt_r != '0);
  assign q_beat    = mem_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // pointer and fill updates
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_beat;
  end

endmodule

FILE: rtl/tga_back.sv
// Back: header capture, phase sequencing, triplet assembly, output register.
// Depends on tga_pkg.
`timescale 1ns / 1ps
module tga_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  tga_pkg::beat_t  q_beat,
  output logic            out_tvalid,
  input  logic            out_tready,
  output tga_pkg::kind_t  out_kind,
  output tga_pkg::res_t   out_res
);
  import tga_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_ID     = 5'b00010,
    PH_MAP    = 5'b00100,
    PH_PIXELS = 5'b01000,
    PH_WAIT   = 5'b10000
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [7:0]  idc_r, idc_nxt;
  logic [7:0]  idlen_r, idlen_nxt, mtype_r, mtype_nxt, msize_r, msize_nxt;
  logic [7:0]  depth_r, depth_nxt, desc_r, desc_nxt;
  logic [15:0] mlen_r, mlen_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [1:0]  tp_r, tp_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] col_r, col_nxt, rowc_r, rowc_nxt, ent_r, ent_nxt;
  logic        ov_r, ov_nxt;
  kind_t       ok_r, ok_nxt;
  res_t        or_r, or_nxt;

  logic        take, map_used, last_col, last_row;
  logic [7:0]  b;

  // accept when the output register is free or draining
  assign q_ready    = !ov_r || out_tready;
  assign take       = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_kind   = ok_r;
  assign out_res    = or_r;
  assign b          = q_beat.data_byte;
  assign map_used   = (mtype_nxt == 8'd1) && (mlen_nxt != '0);
  assign last_col   = (17'(col_r) + 17'd1) >= 17'(w_r);
  assign last_row   = (17'(rowc_r) + 17'd1) >= 17'(h_r);

  always_comb begin
    ph_nxt = ph_r; bc_nxt = bc_r; idc_nxt = idc_r;
    idlen_nxt = idlen_r; mtype_nxt = mtype_r; msize_nxt = msize_r;
    depth_nxt = depth_r; desc_nxt = desc_r; mlen_nxt = mlen_r;
    w_nxt = w_r; h_nxt = h_r; tp_nxt = tp_r; held_nxt = held_r;
    col_nxt = col_r; rowc_nxt = rowc_r; ent_nxt = ent_r;
    ov_nxt = ov_r && !out_tready;
    ok_nxt = ok_r; or_nxt = or_r;
    if (take) begin
      if (q_beat.end_of_stream) begin
        if ((ph_r == PH_HEADER && bc_r != '0) || ph_r == PH_ID ||
            ph_r == PH_MAP || ph_r == PH_PIXELS) begin
          ov_nxt = 1'b1; ok_nxt = KIND_ERROR;
          or_nxt = '0; or_nxt.error_code = ERR_EARLY;
        end
        ph_nxt = PH_HEADER; bc_nxt = '0; tp_nxt = '0; held_nxt = '0;
      end else begin
        unique case (ph_r) inside
          PH_HEADER: begin
            case (bc_r)
              5'd0:  idlen_nxt = b;
              5'd1:  mtype_nxt = b;
              5'd5:  mlen_nxt[7:0] = b;
              5'd6:  mlen_nxt[15:8] = b;
              5'd7:  msize_nxt = b;
              5'd12: w_nxt[7:0] = b;
              5'd13: w_nxt[15:8] = b;
              5'd14: h_nxt[7:0] = b;
              5'd15: h_nxt[15:8] = b;
              5'd16: depth_nxt = b;
              5'd17: desc_nxt = b;
              default: ;
            endcase
            if (bc_r != 5'(HeaderLength-1)) begin
              bc_nxt = bc_r + 1'b1;
            end else begin
              bc_nxt = '0;
              ov_nxt = 1'b1; or_nxt = '0;
              if (map_used && msize_nxt != Depth24) begin
                ok_nxt = KIND_ERROR; or_nxt.error_code = ERR_MAPSZ; ph_nxt = PH_WAIT;
              end else if (depth_nxt != Depth24) begin
                ok_nxt = KIND_ERROR; or_nxt.error_code = ERR_DEPTH; ph_nxt = PH_WAIT;
              end else if (desc_nxt[3:0] != '0) begin
                ok_nxt = KIND_ERROR; or_nxt.error_code = ERR_ALPHA; ph_nxt = PH_WAIT;
              end else begin
                ok_nxt = KIND_HEADER;
                or_nxt.column = w_nxt; or_nxt.row = h_nxt;
                tp_nxt = '0; held_nxt = '0; ent_nxt = '0; idc_nxt = '0;
                col_nxt = '0; rowc_nxt = '0;
                if (idlen_nxt != '0) ph_nxt = PH_ID;
                else if (map_used) ph_nxt = PH_MAP;
                else if (w_nxt != '0 && h_nxt != '0) ph_nxt = PH_PIXELS;
                else ph_nxt = PH_HEADER;
              end
            end
          end
          PH_ID: begin
            idc_nxt = idc_r + 1'b1;
            if (idc_nxt >= idlen_r) begin
              idc_nxt = '0; tp_nxt = '0; held_nxt = '0; ent_nxt = '0;
              col_nxt = '0; rowc_nxt = '0;
              if (mtype_r == 8'd1 && mlen_r != '0) ph_nxt = PH_MAP;
              else if (w_r != '0 && h_r != '0) ph_nxt = PH_PIXELS;
              else ph_nxt = PH_HEADER;
            end
          end
          PH_MAP, PH_PIXELS: begin
            if (tp_r == 2'd0) begin
              held_nxt = {8'd0, b}; tp_nxt = 2'd1;
            end else if (tp_r == 2'd1) begin
              held_nxt = {b, held_r[7:0]}; tp_nxt = 2'd2;
            end else begin
              tp_nxt = '0; ov_nxt = 1'b1; or_nxt = '0;
              or_nxt.red = held_r[7:0]; or_nxt.green = held_r[15:8]; or_nxt.blue = b;
              if (ph_r == PH_MAP) begin
                ok_nxt = KIND_MAP; or_nxt.column = ent_r;
                ent_nxt = ent_r + 1'b1;
                if (ent_nxt >= mlen_r) begin
                  held_nxt = '0; col_nxt = '0; rowc_nxt = '0;
                  ph_nxt = (w_r != '0 && h_r != '0) ? PH_PIXELS : PH_HEADER;
                end
              end else begin
                ok_nxt = KIND_PIXEL; or_nxt.column = col_r;
                or_nxt.row = h_r - 16'd1 - rowc_r;
                if (last_col) begin
                  col_nxt = '0;
                  if (last_row) begin
                    or_nxt.image_done = 1'b1; rowc_nxt = '0;
                    ph_nxt = PH_HEADER; bc_nxt = '0;
                  end else begin
                    rowc_nxt = rowc_r + 1'b1;
                  end
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
            end
          end
          PH_WAIT: ;
          default: ph_nxt = PH_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; bc_r <= '0; idc_r <= '0; idlen_r <= '0;
      mtype_r <= '0; msize_r <= '0; depth_r <= '0; desc_r <= '0;
      mlen_r <= '0; w_r <= '0; h_r <= '0; tp_r <= '0; held_r <= '0;
      col_r <= '0; rowc_r <= '0; ent_r <= '0; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; bc_r <= bc_nxt; idc_r <= idc_nxt; idlen_r <= idlen_nxt;
      mtype_r <= mtype_nxt; msize_r <= msize_nxt; depth_r <= depth_nxt;
      desc_r <= desc_nxt; mlen_r <= mlen_nxt; w_r <= w_nxt; h_r <= h_nxt;
      tp_r <= tp_nxt; held_r <= held_nxt; col_r <= col_nxt;
      rowc_r <= rowc_nxt; ent_r <= ent_nxt; ov_r <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    or_r <= or_nxt;
  end

endmodule

FILE: rtl/tga_stream_parser_top.sv
// Top level of the TGA stream parser: input queue plus parsing back end.
// Depends on tga_pkg, tga_front, tga_back.
//
//  channel | dir | tdata                         | tuser     | tlast
//  in_     | in  | data_byte[7:0]                | -         | end_of_stream
//  out_    | out | red,green,blue,column,row,    | item_kind | -
//          |     | error_code,image_done, pad    |           |
//
// One byte per cycle sustained while out_tready is high; each beat passes the
// two-entry queue and the back end's phase update into the output register.
// A result reaches out_ through the queue memory and then the output register.
// rst_n is synchronous, active low; it empties the queue and returns to header.
// A held result stalls the back end; the queue then fills up to its two entries.
`timescale 1ns / 1ps
module tga_stream_parser_top #(
  parameter int QueueDepth = tga_pkg::QueueDepthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tga_pkg::InDataW-1:0] in_tdata,   // data_byte[7:0]
  input  logic                       in_tlast,    // end_of_stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // red[7:0] green[15:8] blue[23:16] column[39:24] row[55:40]
  // error_code[58:56] image_done[59] zero[63:60]
  output logic [tga_pkg::OutDataW-1:0] out_tdata,
  output logic [tga_pkg::OutUserW-1:0] out_tuser  // item_kind[1:0]
);
  import tga_pkg::*;

  beat_t in_beat, q_beat;
  logic  q_valid, q_ready;
  kind_t kind;
  res_t  res;

  assign in_beat.data_byte     = in_tdata;
  assign in_beat.end_of_stream = in_tlast;

  tga_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_beat,
    .q_valid, .q_ready, .q_beat
  );

  tga_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_beat,
    .out_tvalid, .out_tready, .out_kind(kind), .out_res(res)
  );

  assign out_tdata = {4'd0, res.image_done, res.error_code, res.row, res.column,
                      res.blue, res.green, res.red};
  assign out_tuser = kind;

endmodule

FILE: rtl/tga_checker.sv
// Port-level checker for the TGA stream parser, bound to the top level.
// Depends on tga_pkg and tga_stream_parser_top.
`timescale 1ns / 1ps
module tga_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import tga_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // error code only on error results
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ERROR |-> out_tdata[58:56] == ERR_NONE)
    else $error("error code on non-error result");

  // image done only on pixels
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[59] |-> out_tuser == KIND_PIXEL)
    else $error("image done on non-pixel");

  // out_tvalid is clear straight after a reset cycle
  a_first: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result straight after reset");

  // the emptied queue is ready straight after reset
  a_rdy: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind tga_stream_parser_top tga_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tuser
);
